FILE: rtl/heap_sorter_unit_macros.svh
// assertion macros for the heap sorter unit
`ifndef HEAP_SORTER_UNIT_MACROS_SVH
`define HEAP_SORTER_UNIT_MACROS_SVH

// same-cycle implication, quiet while in reset
`define HSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define HSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hs_pkg.sv
// shared constants and types for the heap sorter unit
package hs_pkg;

  // default store capacity in items
  localparam int DEF_MAX_ITEMS = 64;

  // item value width
  localparam int DATA_W = 32;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_TOP_RD  = 6'b000010,
    S_TOP_WT  = 6'b000100,
    S_KID_RD  = 6'b001000,
    S_KID_CMP = 6'b010000,
    S_OUT     = 6'b100000
  } state_t;

endpackage

FILE: rtl/heap_sorter_unit.sv
// heap sorter unit: batch load, in-place heap sort, ascending read-out
// load: one item per start cycle, busy stays low until the item with the last mark
// sort: sift pass setup TOP_RD/TOP_WT, KID_RD+KID_CMP per compare level, KID_RD at a leaf;
//   one pass per internal node (n/2) and one per extraction (n), one dual-read store
// read-out: registered read, then n results on consecutive cycles, receiver cannot stall;
//   busy drops with the final result; synchronous reset empties the batch, clears overflow
module heap_sorter_unit #(
  parameter int MAX_ITEMS = hs_pkg::DEF_MAX_ITEMS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [hs_pkg::DATA_W-1:0] in_value,
  input  logic                            in_last,
  output logic                            out_strobe,
  output logic signed [hs_pkg::DATA_W-1:0] out_value_res,
  output logic                            out_last_res,
  output logic                            out_overflow
);

  `include "heap_sorter_unit_macros.svh"

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int KW = CW + 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  // item store, two registered read ports and one write port
  logic signed [hs_pkg::DATA_W-1:0] mem [MAX_ITEMS];
  logic signed [hs_pkg::DATA_W-1:0] rdata_a_r, rdata_b_r;
  logic [AW-1:0]                    raddr_a, raddr_b, waddr;
  logic signed [hs_pkg::DATA_W-1:0] wdata;
  logic                             we;

  // control and datapath registers
  hs_pkg::state_t                   state_r, state_nxt;
  logic [CW-1:0]                    count_r, count_nxt;
  logic                             ovf_r, ovf_nxt;
  logic                             ext_r, ext_nxt;
  logic [CW-1:0]                    top_r, top_nxt;
  logic [CW-1:0]                    end_r, end_nxt;
  logic [KW-1:0]                    node_r, node_nxt;
  logic [KW-1:0]                    kid_r, kid_nxt;
  logic signed [hs_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [CW-1:0]                    idx_r, idx_nxt;
  logic                             strobe_r, strobe_nxt;
  logic                             olast_r, olast_nxt;
  logic                             oovf_r, oovf_nxt;

  // helpers
  logic [CW-1:0]                    n_load;
  logic                             kid_out;
  logic                             use_right;
  logic signed [hs_pkg::DATA_W-1:0] child;
  logic                             do_swap;
  logic                             sift_done;
  logic [KW-1:0]                    node_m1, kid_m1, top_m1;

  assign node_m1 = node_r - KW'(1);
  assign kid_m1  = kid_r - KW'(1);
  assign top_m1  = {1'b0, top_r} - KW'(1);

  // count after the item now offered
  assign n_load = (count_r < CNT_MAX) ? count_r + CNT_ONE : count_r;

  // child selection and swap compare
  assign kid_out   = kid_r > {1'b0, end_r};
  assign use_right = (kid_r < {1'b0, end_r}) && (rdata_b_r > rdata_a_r);
  assign child     = use_right ? rdata_b_r : rdata_a_r;
  assign do_swap   = val_r < child;
  assign sift_done = (state_r == hs_pkg::S_KID_RD && kid_out) ||
                     (state_r == hs_pkg::S_KID_CMP && !do_swap);

  // store read addresses
  always_comb begin
    raddr_a = kid_m1[AW-1:0];
    raddr_b = kid_r[AW-1:0];
    unique case (state_r)
      hs_pkg::S_TOP_RD: begin
        raddr_a = top_m1[AW-1:0];
        raddr_b = '0;
      end
      hs_pkg::S_OUT: begin
        raddr_a = idx_r[AW-1:0];
        raddr_b = '0;
      end
      default: begin
        raddr_a = kid_m1[AW-1:0];
        raddr_b = kid_r[AW-1:0];
      end
    endcase
  end

  // store write port
  always_comb begin
    we    = 1'b0;
    waddr = node_m1[AW-1:0];
    wdata = val_r;
    unique case (state_r)
      hs_pkg::S_IDLE: begin
        we    = start && (count_r < CNT_MAX);
        waddr = count_r[AW-1:0];
        wdata = in_value;
      end
      hs_pkg::S_TOP_WT: begin
        we    = ext_r;
        waddr = top_m1[AW-1:0];
        wdata = rdata_b_r;
      end
      hs_pkg::S_KID_RD: begin
        we    = kid_out;
        waddr = node_m1[AW-1:0];
        wdata = val_r;
      end
      hs_pkg::S_KID_CMP: begin
        we    = 1'b1;
        waddr = node_m1[AW-1:0];
        wdata = do_swap ? child : val_r;
      end
      default: begin
        we    = 1'b0;
        waddr = node_m1[AW-1:0];
        wdata = val_r;
      end
    endcase
  end

  // store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    ext_nxt    = ext_r;
    top_nxt    = top_r;
    end_nxt    = end_r;
    node_nxt   = node_r;
    kid_nxt    = kid_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    strobe_nxt = 1'b0;
    olast_nxt  = olast_r;
    oovf_nxt   = oovf_r;
    unique case (state_r)
      hs_pkg::S_IDLE: begin
        if (start) begin
          count_nxt = n_load;
          if (count_r == CNT_MAX) begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = hs_pkg::S_TOP_RD;
            if ((n_load >> 1) == '0) begin
              ext_nxt = 1'b1;
              top_nxt = n_load;
            end else begin
              ext_nxt = 1'b0;
              top_nxt = n_load >> 1;
            end
          end
        end
      end
      hs_pkg::S_TOP_RD: begin
        state_nxt = hs_pkg::S_TOP_WT;
      end
      hs_pkg::S_TOP_WT: begin
        // value to sift; extraction moves the root into the freed slot
        state_nxt = hs_pkg::S_KID_RD;
        val_nxt   = rdata_a_r;
        if (ext_r) begin
          node_nxt = KW'(1);
          kid_nxt  = KW'(2);
          end_nxt  = top_r - CNT_ONE;
        end else begin
          node_nxt = {1'b0, top_r};
          kid_nxt  = {top_r, 1'b0};
          end_nxt  = count_r;
        end
      end
      hs_pkg::S_KID_RD: begin
        if (!kid_out) begin
          state_nxt = hs_pkg::S_KID_CMP;
        end
      end
      hs_pkg::S_KID_CMP: begin
        if (do_swap) begin
          state_nxt = hs_pkg::S_KID_RD;
          node_nxt  = use_right ? kid_r + KW'(1) : kid_r;
          kid_nxt   = use_right ? {kid_r[KW-2:0], 1'b0} + KW'(2) : {kid_r[KW-2:0], 1'b0};
        end
      end
      hs_pkg::S_OUT: begin
        strobe_nxt = 1'b1;
        olast_nxt  = (idx_r + CNT_ONE) == count_r;
        oovf_nxt   = ovf_r;
        idx_nxt    = idx_r + CNT_ONE;
        if ((idx_r + CNT_ONE) == count_r) begin
          state_nxt = hs_pkg::S_IDLE;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = hs_pkg::S_IDLE;
      end
    endcase

    // end of one sift pass: next internal node, next extraction or read-out
    if (sift_done) begin
      if (top_r == CNT_ONE) begin
        if (ext_r) begin
          state_nxt = hs_pkg::S_OUT;
          idx_nxt   = '0;
        end else begin
          state_nxt = hs_pkg::S_TOP_RD;
          ext_nxt   = 1'b1;
          top_nxt   = count_r;
        end
      end else begin
        state_nxt = hs_pkg::S_TOP_RD;
        top_nxt   = top_r - CNT_ONE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= hs_pkg::S_IDLE;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ext_r   <= ext_nxt;
    top_r   <= top_nxt;
    end_r   <= end_nxt;
    node_r  <= node_nxt;
    kid_r   <= kid_nxt;
    val_r   <= val_nxt;
    idx_r   <= idx_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= oovf_nxt;
  end

  // outputs
  assign busy          = (state_r != hs_pkg::S_IDLE);
  assign out_strobe    = strobe_r;
  assign out_value_res = rdata_a_r;
  assign out_last_res  = strobe_r && olast_r;
  assign out_overflow  = strobe_r && oovf_r;

  // checks
  `HSU_ASSERT_NEXT(a_out_follows_read, state_r == hs_pkg::S_OUT, out_strobe,
    "read-out cycle not followed by a result")
  `HSU_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_MAX,
    "item count exceeds store capacity")
  `HSU_ASSERT_NEXT(a_last_ends_batch, out_strobe && out_last_res,
    !out_strobe, "results continue after the last item of the batch")

endmodule
